FILE: sv/nce_pkg.sv
// Shared types, constants and helper functions for the name component escaper.
package nce_pkg;

  localparam int unsigned MAX_DOT_RUN = 65535;
  // The dot counter is 16 bits wide, so it saturates at the smaller of the two limits.
  localparam logic [15:0] DOT_CAP = (MAX_DOT_RUN < 65535) ? 16'(MAX_DOT_RUN) : 16'hFFFF;

  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;

  localparam logic [16:0] ALL_DOT_EXTRA = 17'd3;

  typedef enum logic [1:0] {
    ENC_NONE,
    ENC_PASS,
    ENC_ESC
  } enc_t;

  typedef enum logic [1:0] {
    PH_RUN,
    PH_CHAR,
    PH_HI,
    PH_LO
  } phase_t;

  // One classified item: an optional dot run, then a bare marker or an encoded byte.
  typedef struct packed {
    logic [7:0]  byte_val;
    logic [16:0] run_len;
    logic        has_run;
    logic        bare;
    enc_t        enc;
    logic        last;
  } cmd_t;

  function automatic logic passes(input logic [7:0] x);
    passes = (x >= CH_0 && x <= CH_9) || (x >= CH_UA && x <= CH_UZ) ||
             (x >= CH_LA && x <= CH_LZ) || x == CH_PLUS || x == CH_MINUS ||
             x == CH_DOT || x == CH_UNDER;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    hex_digit = (v < 4'd10) ? (CH_0 + {4'd0, v}) : (CH_UA + {4'd0, v} - 8'd10);
  endfunction

endpackage

FILE: sv/nce_in_if.sv
// Input channel: one component byte per transfer.
interface nce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       present;
  logic       ends_component;

  modport source (output valid, output data_byte, output present, output ends_component,
                  input ready);
  modport sink (input valid, input data_byte, input present, input ends_component,
                output ready);
endinterface

FILE: sv/nce_out_if.sv
// Output channel: one character with a repeat count per transfer.
interface nce_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic [16:0] repeat_count;
  logic        final_res;

  modport source (output valid, output out_char, output repeat_count, output final_res,
                  input ready);
  modport sink (input valid, input out_char, input repeat_count, input final_res,
                output ready);
endinterface

FILE: sv/nce_front.sv
// Front end: accepts input bytes, tracks leading periods and classifies each item.
module nce_front import nce_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  nce_in_if.sink   items,
  input  logic     q_full,
  output logic     push,
  output cmd_t     push_cmd
);

  logic [15:0] dot_run, dot_run_next;
  logic        seen_other, seen_other_next;
  logic        accept;
  logic        produce;
  cmd_t        cmd;

  assign items.ready = !q_full;
  assign accept      = items.valid && items.ready;

  always_comb begin
    dot_run_next    = dot_run;
    seen_other_next = seen_other;
    cmd             = '0;
    cmd.enc         = ENC_NONE;
    cmd.byte_val    = items.data_byte;

    if (items.present) begin
      if (seen_other) begin
        cmd.enc = passes(items.data_byte) ? ENC_PASS : ENC_ESC;
      end else if (items.data_byte == CH_DOT) begin
        if (dot_run < DOT_CAP) begin
          dot_run_next = dot_run + 16'd1;
        end
      end else begin
        cmd.has_run     = (dot_run != 16'd0);
        cmd.run_len     = {1'b0, dot_run};
        cmd.enc         = passes(items.data_byte) ? ENC_PASS : ENC_ESC;
        seen_other_next = 1'b1;
        dot_run_next    = 16'd0;
      end
    end

    if (items.ends_component) begin
      if (!seen_other_next) begin
        // A component of periods only comes out as one longer run.
        cmd.has_run = 1'b1;
        cmd.run_len = {1'b0, dot_run_next} + ALL_DOT_EXTRA;
      end else if (!cmd.has_run && cmd.enc == ENC_NONE) begin
        cmd.bare = 1'b1;
      end
      cmd.last        = 1'b1;
      dot_run_next    = 16'd0;
      seen_other_next = 1'b0;
    end
  end

  assign produce  = cmd.has_run || cmd.bare || (cmd.enc != ENC_NONE);
  assign push     = accept && produce;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_run    <= 16'd0;
      seen_other <= 1'b0;
    end else if (accept) begin
      dot_run    <= dot_run_next;
      seen_other <= seen_other_next;
    end
  end

endmodule

FILE: sv/nce_queue.sv
// Short command queue between the front end and the output sequencer.
module nce_queue import nce_pkg::*; #(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: sv/nce_back.sv
// Back end: expands each queued command into output characters, one per cycle while the result channel accepts them.
module nce_back import nce_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     head_valid,
  input  cmd_t     head_cmd,
  output logic     pop,
  nce_out_if.source results
);

  phase_t      phase, phase_next, cur;
  logic        mid, mid_next;
  logic        is_last;
  logic        load;
  logic        emit;
  logic [7:0]  res_char;
  logic [16:0] res_count;

  logic        out_valid;
  logic [7:0]  out_char;
  logic [16:0] out_count;
  logic        out_final;

  assign load = !out_valid || results.ready;
  assign emit = load && head_valid;
  // At the start of a command the first step follows from what it carries.
  assign cur  = mid ? phase : (head_cmd.has_run ? PH_RUN : PH_CHAR);

  always_comb begin
    is_last    = 1'b0;
    phase_next = cur;
    unique case (cur)
      PH_RUN: begin
        is_last    = (head_cmd.enc == ENC_NONE) && !head_cmd.bare;
        phase_next = PH_CHAR;
      end
      PH_CHAR: begin
        is_last    = (head_cmd.enc != ENC_ESC);
        phase_next = PH_HI;
      end
      PH_HI: begin
        is_last    = 1'b0;
        phase_next = PH_LO;
      end
      PH_LO: begin
        is_last    = 1'b1;
        phase_next = PH_RUN;
      end
      default: begin
        is_last    = 1'b1;
        phase_next = PH_RUN;
      end
    endcase
    mid_next = !is_last;
  end

  always_comb begin
    res_char  = CH_NUL;
    res_count = 17'd1;
    unique case (cur)
      PH_RUN: begin
        res_char  = CH_DOT;
        res_count = head_cmd.run_len;
      end
      PH_CHAR: begin
        if (head_cmd.bare) begin
          res_char  = CH_NUL;
          res_count = 17'd0;
        end else if (head_cmd.enc == ENC_ESC) begin
          res_char = CH_PCT;
        end else begin
          res_char = head_cmd.byte_val;
        end
      end
      PH_HI:   res_char = hex_digit(head_cmd.byte_val[7:4]);
      PH_LO:   res_char = hex_digit(head_cmd.byte_val[3:0]);
      default: res_char = CH_NUL;
    endcase
  end

  assign pop = emit && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_RUN;
      mid       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        phase <= phase_next;
        mid   <= mid_next;
      end
      if (load) begin
        out_valid <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char  <= res_char;
      out_count <= res_count;
      out_final <= is_last && head_cmd.last;
    end
  end

  assign results.valid        = out_valid;
  assign results.out_char     = out_char;
  assign results.repeat_count = out_count;
  assign results.final_res    = out_final;

endmodule

FILE: sv/name_component_escape.sv
// Top level of the name component escaper: front end, command queue and output sequencer.
//
//   channel   dir   payload                                       transfer when
//   items     in    data_byte[7:0], present, ends_component       valid && ready
//   results   out   out_char[7:0], repeat_count[16:0], final_res  valid && ready
//
// The output side produces one character per cycle while results is not stalled: a passing
// byte gives one result, an escaped byte three, and a held dot run adds one. The output sequencer sets the rate.
// Items that produce no character (a held leading period) are absorbed in the front end.
// The queue holds QUEUE_DEPTH classified items, so input keeps flowing while output stalls until the queue is full.
// Reset is synchronous and clears the dot counter, the queue and the output valid flag.
module name_component_escape import nce_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  nce_in_if.sink    items,
  nce_out_if.source results
);

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  nce_front u_front (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  nce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  nce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .results    (results)
  );

endmodule

FILE: sv/nce_checker.sv
// Port-level checker for the name component escaper and its bind to the top level.
module nce_checker import nce_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_char,
  input logic [16:0] repeat_count,
  input logic        final_res
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
      $stable(repeat_count) && $stable(final_res))
    else $error("stalled result changed");

  // A zero count is only the bare end marker.
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && repeat_count == 17'd0 |-> out_char == CH_NUL && final_res)
    else $error("zero repeat count on a result that is not a bare end marker");

  // A percent sign always starts an escape, so it is single and never last.
  a_pct_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_char == CH_PCT |-> repeat_count == 17'd1 && !final_res)
    else $error("percent sign repeated or ending a component");

  // Nothing comes out right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind name_component_escape nce_checker u_nce_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_char     (results.out_char),
  .repeat_count (results.repeat_count),
  .final_res    (results.final_res)
);
